### rtl/core/pixel_compositor_macros.svh
// assertion macros shared by the compositor rtl
// no dependencies; the including module provides aclk and aresetn
`ifndef PIXEL_COMPOSITOR_MACROS_SVH
`define PIXEL_COMPOSITOR_MACROS_SVH

// same-cycle implication, checked on aclk, off while aresetn is low
`define PXC_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("pixel_compositor check failed");

// next-cycle implication, checked on aclk, off while aresetn is low
`define PXC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("pixel_compositor check failed");

`endif

### rtl/core/pxc_pkg.sv
// types, codes and helper functions of the pixel compositor
// no dependencies; used by pxc_src_sel and pixel_compositor
`default_nettype none

package pxc_pkg;

    // mode codes
    localparam logic [3:0] MODE_COPY       = 4'd0;
    localparam logic [3:0] MODE_BLEND      = 4'd1;
    localparam logic [3:0] MODE_AVG_BLEND  = 4'd2;
    localparam logic [3:0] MODE_AVG_COPY   = 4'd3;
    localparam logic [3:0] MODE_FILL       = 4'd4;
    localparam logic [3:0] MODE_FILL_BLEND = 4'd5;
    localparam logic [3:0] MODE_GLYPH      = 4'd6;
    localparam logic [3:0] MODE_SWAP       = 4'd7;
    localparam logic [3:0] MODE_MASK       = 4'd8;

    // configuration register indexes
    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_FILL_COLOR = 2'd1;
    localparam logic [1:0] REG_SWAP_OLD   = 2'd2;
    localparam logic [1:0] REG_SWAP_NEW   = 2'd3;

    // reset values
    localparam logic [3:0]  MODE_RESET       = MODE_BLEND;
    localparam logic [31:0] FILL_COLOR_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] SWAP_RESET       = 32'h0000_0000;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // blend source and bypass word, handed from selection to the multiply stage
    typedef struct packed {
        logic        blend;   // a real mix is needed
        logic [7:0]  alpha;
        logic [23:0] s_rgb;
        logic [23:0] d_rgb;
        logic [31:0] direct;  // result when no mix is needed
    } pxc_sel_t;

    // x / 255 for x up to 255*255: estimate low by at most one, then correct
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        logic [7:0]  q;
        logic [15:0] r;
        t = {1'b0, x} + {9'b0, x[15:8]};
        q = t[15:8];
        r = x - {q, 8'b0} + {8'b0, q};
        if (r >= 16'd255) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pxc_src_sel.sv
// source selection of the compositor: pair average, fill, glyph alpha, swap, mask
// depends on pxc_pkg for mode codes and the pxc_sel_t struct
`default_nettype none

module pxc_src_sel (
    input  wire logic [3:0]  mode,
    input  wire logic [31:0] fill_color,
    input  wire logic [31:0] swap_old,
    input  wire logic [31:0] swap_new,
    input  wire logic [31:0] src_pixel,
    input  wire logic [31:0] src_pixel_next,
    input  wire logic [31:0] dst_pixel,
    input  wire logic [7:0]  coverage,
    output pxc_pkg::pxc_sel_t sel
);

    logic [31:0] avg_word;
    logic [31:0] blend_src;
    logic        use_blend;

    // bytewise pair average, truncated
    always_comb begin
        logic [8:0] sum;
        for (int i = 0; i < 4; i++) begin
            sum = {1'b0, src_pixel[8*i +: 8]} + {1'b0, src_pixel_next[8*i +: 8]};
            avg_word[8*i +: 8] = sum[8:1];
        end
    end

    // pick the operation
    always_comb begin
        blend_src  = src_pixel;
        use_blend  = 1'b0;
        sel.direct = dst_pixel;
        unique case (mode)
            pxc_pkg::MODE_COPY:       sel.direct = src_pixel;
            pxc_pkg::MODE_BLEND: begin
                blend_src = src_pixel;
                use_blend = 1'b1;
            end
            pxc_pkg::MODE_AVG_BLEND: begin
                blend_src = avg_word;
                use_blend = 1'b1;
            end
            pxc_pkg::MODE_AVG_COPY:   sel.direct = avg_word;
            pxc_pkg::MODE_FILL:       sel.direct = fill_color;
            pxc_pkg::MODE_FILL_BLEND: begin
                blend_src = fill_color;
                use_blend = 1'b1;
            end
            // zero coverage gives alpha zero, so the destination passes
            pxc_pkg::MODE_GLYPH: begin
                blend_src = {coverage, fill_color[23:0]};
                use_blend = 1'b1;
            end
            pxc_pkg::MODE_SWAP:
                sel.direct = (dst_pixel == swap_old) ? swap_new : dst_pixel;
            pxc_pkg::MODE_MASK:       sel.direct = {coverage, dst_pixel[23:0]};
            default:                  sel.direct = dst_pixel;
        endcase

        // clear and opaque alpha bypass the multiply
        sel.blend = 1'b0;
        if (use_blend) begin
            priority if (blend_src[31:24] == pxc_pkg::ALPHA_CLEAR) begin
                sel.direct = dst_pixel;
            end else if (blend_src[31:24] == pxc_pkg::ALPHA_OPAQUE) begin
                sel.direct = blend_src;
            end else begin
                sel.blend = 1'b1;
            end
        end
        sel.alpha = blend_src[31:24];
        sel.s_rgb = blend_src[23:0];
        sel.d_rgb = dst_pixel[23:0];
    end

endmodule

`default_nettype wire

### rtl/core/pixel_compositor.sv
// top level of the pixel compositor: config registers and the four-stage pipeline
// depends on pxc_pkg, pxc_src_sel and pixel_compositor_macros.svh
//
//   channel  dir  payload                                          handshake
//   s_       in   s_tdata[103:0] src, src_next, dst, coverage      s_tvalid / s_tready
//   m_       out  m_tdata[31:0] out_pixel                          m_tvalid / m_tready
//   cfg_     in   cfg_wr_index[1:0], cfg_wr_data[31:0]             cfg_wr_en
//
// one word per cycle sustained while m_tready is high; an accepted word passes four registers before m_tvalid
// stages: input register, source select, channel multiply, divide by 255 into output
// each stage holds when the next one is full and stalled, and fills bubbles when free
// aresetn is synchronous active low, clears valid bits and loads config registers with their reset values
`default_nettype none
`include "pixel_compositor_macros.svh"

module pixel_compositor (
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] src_pixel, [63:32] src_pixel_next, [95:64] dst_pixel, [103:96] coverage
    input  wire logic [103:0] s_tdata,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] out_pixel
    output logic [31:0]       m_tdata,

    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_wr_index,
    input  wire logic [31:0]  cfg_wr_data
);

    logic [3:0]  mode_reg;
    logic [31:0] fill_color_reg;
    logic [31:0] swap_old_reg;
    logic [31:0] swap_new_reg;

    logic        v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic        rdy1, rdy2, rdy3, rdy_out;

    logic [103:0]       in_word_reg;
    pxc_pkg::pxc_sel_t  sel_next;
    pxc_pkg::pxc_sel_t  sel_reg;
    logic [15:0]        sum_next [3];
    logic [15:0]        sum_reg  [3];
    logic               blend3_reg;
    logic [31:0]        direct3_reg;
    logic [31:0]        out_next;
    logic [31:0]        out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= pxc_pkg::MODE_RESET;
            fill_color_reg <= pxc_pkg::FILL_COLOR_RESET;
            swap_old_reg   <= pxc_pkg::SWAP_RESET;
            swap_new_reg   <= pxc_pkg::SWAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                pxc_pkg::REG_MODE:       mode_reg       <= cfg_wr_data[3:0];
                pxc_pkg::REG_FILL_COLOR: fill_color_reg <= cfg_wr_data;
                pxc_pkg::REG_SWAP_OLD:   swap_old_reg   <= cfg_wr_data;
                pxc_pkg::REG_SWAP_NEW:   swap_new_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // per-stage ready: a stage may load when empty or when it drains this cycle
    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg      <= s_tvalid;
            if (rdy2)    v2_reg      <= v1_reg;
            if (rdy3)    v3_reg      <= v2_reg;
            if (rdy_out) m_valid_reg <= v3_reg;
        end
    end

    // stage 1: input word
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            in_word_reg <= s_tdata;
        end
    end

    // stage 2: source selection
    pxc_src_sel u_src_sel (
        .mode           (mode_reg),
        .fill_color     (fill_color_reg),
        .swap_old       (swap_old_reg),
        .swap_new       (swap_new_reg),
        .src_pixel      (in_word_reg[31:0]),
        .src_pixel_next (in_word_reg[63:32]),
        .dst_pixel      (in_word_reg[95:64]),
        .coverage       (in_word_reg[103:96]),
        .sel            (sel_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            sel_reg <= sel_next;
        end
    end

    // stage 3: s*a + d*(255-a) per color channel
    always_comb begin
        logic [7:0] inv_a;
        inv_a = pxc_pkg::ALPHA_OPAQUE - sel_reg.alpha;
        for (int c = 0; c < 3; c++) begin
            sum_next[c] = {8'b0, sel_reg.s_rgb[8*c +: 8]} * {8'b0, sel_reg.alpha}
                        + {8'b0, sel_reg.d_rgb[8*c +: 8]} * {8'b0, inv_a};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sum_reg     <= sum_next;
            blend3_reg  <= sel_reg.blend;
            direct3_reg <= sel_reg.direct;
        end
    end

    // stage 4: divide by 255 and merge with the bypass word
    always_comb begin
        if (blend3_reg) begin
            out_next = {pxc_pkg::ALPHA_OPAQUE, pxc_pkg::div255(sum_reg[2]),
                        pxc_pkg::div255(sum_reg[1]), pxc_pkg::div255(sum_reg[0])};
        end else begin
            out_next = direct3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // a full pipeline is the only reason to refuse input
    `PXC_ASSERT_NOW(a_ready_only_when_full, !s_tready,
        v1_reg && v2_reg && v3_reg && m_valid_reg)
    // a stalled multiply stage keeps its word
    `PXC_ASSERT_NEXT(a_stage3_holds, v3_reg && !rdy_out, v3_reg && $stable(direct3_reg))
    // mixed words come out opaque
    `PXC_ASSERT_NEXT(a_blend_opaque, v3_reg && rdy_out && blend3_reg,
        m_tdata[31:24] == pxc_pkg::ALPHA_OPAQUE)
    // channel sums never exceed 255*255
    `PXC_ASSERT_NOW(a_sum_range, v3_reg && blend3_reg,
        sum_reg[0] <= 16'd65025 && sum_reg[1] <= 16'd65025 && sum_reg[2] <= 16'd65025)

endmodule

`default_nettype wire
